>>> rtl/core/http_header_field_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// http_header_field_scanner_top_macros.svh
// Assertion macros used by the header scanner parser (hhfs_parse).
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_FIELD_SCANNER_TOP_MACROS_SVH
`define HTTP_HEADER_FIELD_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HHFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhfs: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define HHFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhfs: next-cycle check failed");

`endif

>>> rtl/core/hhfs_pkg.sv
// ----------------------------------------------------------------------------
// hhfs_pkg
// Types, codes and constants of the HTTP header field scanner.
// ----------------------------------------------------------------------------
package hhfs_pkg;

  localparam int LEN_W                = 9;
  localparam int TEXT_STORE_BYTES_DEF = 512;
  localparam logic [LEN_W-1:0] MAX_TEXT_RESET = 9'd511;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Item opcodes
  typedef enum logic {
    OP_TEXT    = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  // Parser phase
  typedef enum logic [2:0] {
    PH_KEY_WS = 3'd0,
    PH_KEY    = 3'd1,
    PH_COLON  = 3'd2,
    PH_VAL_WS = 3'd3,
    PH_VAL    = 3'd4,
    PH_ERROR  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  // Event codes reported per byte
  typedef enum logic [3:0] {
    EV_SKIP    = 4'd0,
    EV_KEY     = 4'd1,
    EV_COLON   = 4'd2,
    EV_VALUE   = 4'd3,
    EV_FIELD   = 4'd4,
    EV_HEADER  = 4'd5,
    EV_SYNTAX  = 4'd6,
    EV_LONG    = 4'd7,
    EV_IGNORED = 4'd8
  } event_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [LEN_W-1:0] key_length;
    logic [LEN_W-1:0] value_length;
  } out_item_t;

  // Space, or tab through carriage return
  function automatic logic is_ws(input logic [7:0] c);
    logic res;
    res = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    return res;
  endfunction

endpackage

>>> rtl/core/hhfs_stream_if.sv
// ----------------------------------------------------------------------------
// hhfs_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface hhfs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/hhfs_cfg.sv
// ----------------------------------------------------------------------------
// hhfs_cfg
// APB register for the text length limit and the effective limit it sets.
// ----------------------------------------------------------------------------
module hhfs_cfg import hhfs_pkg::*; #(
  parameter int TEXT_STORE_BYTES = TEXT_STORE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [LEN_W-1:0] limit
);

  localparam int StoreMax = TEXT_STORE_BYTES - 1;
  localparam logic [LEN_W-1:0] StoreLim =
    (StoreMax > ((1 << LEN_W) - 1)) ? {LEN_W{1'b1}} : LEN_W'(StoreMax);

  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W-1:0] max_len_nxt;
  logic             reg_hit;

  // Byte addresses 0 to 3 (paddr[2] low) all decode to the one register
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite && reg_hit) begin
      max_len_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_TEXT_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // Read back
  assign prdata = reg_hit ? {{(32-LEN_W){1'b0}}, max_len_r} : 32'd0;

  // Effective limit is bounded by the text store
  assign limit = (max_len_r < StoreLim) ? max_len_r : StoreLim;

endmodule

>>> rtl/core/hhfs_parse.sv
// ----------------------------------------------------------------------------
// hhfs_parse
// Input register, per-byte parser step and result register.
// ----------------------------------------------------------------------------
`include "http_header_field_scanner_top_macros.svh"

module hhfs_parse import hhfs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] limit,
  hhfs_stream_if.sink      in_if,
  hhfs_stream_if.source    out_if
);

  // Input register
  logic             in_vld_r;
  logic             op_r;
  logic [7:0]       byte_r;
  // Parser state
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] key_cnt_r, key_cnt_nxt;
  logic [LEN_W-1:0] val_cnt_r, val_cnt_nxt;
  logic [LEN_W-1:0] val_trim_r, val_trim_nxt;
  // Result register
  logic             out_vld_r;
  out_item_t        out_r;
  out_item_t        res_nxt;

  logic             advance;
  logic             lf, ws, colon;
  logic             key_full, val_full;
  event_t           ev;
  logic [LEN_W-1:0] klen, vlen;

  // Result stage frees when empty or being taken
  assign advance     = !out_vld_r || out_if.ready;
  assign in_if.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      op_r   <= in_if.data.opcode;
      byte_r <= in_if.data.byte_in;
    end
  end

  // Byte classes
  assign lf    = (byte_r == CHAR_LF);
  assign ws    = is_ws(byte_r);
  assign colon = (byte_r == CHAR_COLON);

  assign key_full = ({1'b0, key_cnt_r} + 10'd1) > {1'b0, limit};
  assign val_full = ({1'b0, val_cnt_r} + 10'd1) > {1'b0, limit};

  // Parser step: next phase, counts and event
  always_comb begin
    phase_nxt    = phase_r;
    key_cnt_nxt  = key_cnt_r;
    val_cnt_nxt  = val_cnt_r;
    val_trim_nxt = val_trim_r;
    ev           = EV_IGNORED;
    if (op_r == OP_RESTART) begin
      phase_nxt    = PH_KEY_WS;
      key_cnt_nxt  = '0;
      val_cnt_nxt  = '0;
      val_trim_nxt = '0;
      ev           = EV_SKIP;
    end else begin
      unique case (phase_r)
        PH_KEY_WS, PH_KEY: begin
          if (lf) begin
            phase_nxt = (phase_r == PH_KEY_WS) ? PH_DONE : PH_ERROR;
            ev        = (phase_r == PH_KEY_WS) ? EV_HEADER : EV_SYNTAX;
          end else if (colon) begin
            phase_nxt = PH_VAL_WS;
            ev        = EV_COLON;
          end else if (ws) begin
            if (phase_r == PH_KEY) phase_nxt = PH_COLON;
            ev = EV_SKIP;
          end else if (key_full) begin
            phase_nxt = PH_ERROR;
            ev        = EV_LONG;
          end else begin
            key_cnt_nxt = key_cnt_r + 1'b1;
            phase_nxt   = PH_KEY;
            ev          = EV_KEY;
          end
        end
        PH_COLON: begin
          if (colon) begin
            phase_nxt = PH_VAL_WS;
            ev        = EV_COLON;
          end else if (ws && !lf) begin
            ev = EV_SKIP;
          end else begin
            phase_nxt = PH_ERROR;
            ev        = EV_SYNTAX;
          end
        end
        PH_VAL_WS, PH_VAL: begin
          if (lf) begin
            if (phase_r == PH_VAL) begin
              ev = EV_FIELD;
            end else begin
              phase_nxt = PH_ERROR;
              ev        = EV_SYNTAX;
            end
          end else if (ws && (phase_r == PH_VAL_WS)) begin
            ev = EV_SKIP;
          end else if (val_full) begin
            phase_nxt = PH_ERROR;
            ev        = EV_LONG;
          end else begin
            val_cnt_nxt = val_cnt_r + 1'b1;
            if (!ws) val_trim_nxt = val_cnt_r + 1'b1;
            phase_nxt = PH_VAL;
            ev        = EV_VALUE;
          end
        end
        default: begin
          ev = EV_IGNORED;
        end
      endcase
    end
    // Lengths are reported before a finished field clears the counts
    klen = key_cnt_nxt;
    vlen = val_trim_nxt;
    if (ev == EV_FIELD) begin
      phase_nxt    = PH_KEY_WS;
      key_cnt_nxt  = '0;
      val_cnt_nxt  = '0;
      val_trim_nxt = '0;
    end
    res_nxt.event_res    = ev;
    res_nxt.key_length   = klen;
    res_nxt.value_length = vlen;
  end

  // State moves on only when the item passes to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KEY_WS;
      key_cnt_r  <= '0;
      val_cnt_r  <= '0;
      val_trim_r <= '0;
    end else if (in_vld_r && advance) begin
      phase_r    <= phase_nxt;
      key_cnt_r  <= key_cnt_nxt;
      val_cnt_r  <= val_cnt_nxt;
      val_trim_r <= val_trim_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;

  // Checks
  `HHFS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !advance,
                    in_vld_r && $stable(op_r) && $stable(byte_r))
  `HHFS_ASSERT_NEXT(a_field_clears, clk, rst_n,
                    in_vld_r && advance && (ev == EV_FIELD),
                    (key_cnt_r == '0) && (val_cnt_r == '0) && (phase_r == PH_KEY_WS))
  `HHFS_ASSERT_NOW(a_trim_le_count, clk, rst_n, 1'b1, val_trim_r <= val_cnt_r)
  `HHFS_ASSERT_NOW(a_sticky_ignore, clk, rst_n,
                   in_vld_r && (op_r == OP_TEXT) &&
                   ((phase_r == PH_ERROR) || (phase_r == PH_DONE)),
                   ev == EV_IGNORED)

endmodule

>>> rtl/core/http_header_field_scanner_top.sv
// ----------------------------------------------------------------------------
// http_header_field_scanner_top
// HTTP header field scanner: tags each header byte with a parse event.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one item per byte: opcode (text byte or restart) and
//   byte_in. out_if returns exactly one result per item: event_res,
//   key_length and value_length, in input order.
//   The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//   max_text_length at byte address 0; write it only while the block is idle.
//   The result passes from the input register through the parser step into
//   the result register. Throughput is one item per cycle while out_if.ready
//   stays high; the parser step is a single small state update between the
//   two registers.
//   When the receiver stalls, the result register holds and an empty input
//   register still takes one more item, after which in_if.ready drops.
//   Synchronous reset empties both stages, clears the parser state and sets
//   max_text_length to 511. A restart item clears the parser state and any error.
// ----------------------------------------------------------------------------
module http_header_field_scanner_top import hhfs_pkg::*; #(
  parameter int TEXT_STORE_BYTES = TEXT_STORE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hhfs_stream_if.sink   in_if,
  hhfs_stream_if.source out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [LEN_W-1:0] limit;

  // Configuration register
  hhfs_cfg #(
    .TEXT_STORE_BYTES(TEXT_STORE_BYTES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  // Parser pipeline
  hhfs_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .limit  (limit),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule
